>>> rtl/stereo_linear_resampler_macros.svh
// ----------------------------------------------------------------------------
// Stereo linear resampler assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_MACROS_SVH

`ifndef SYNTHESIS
`define SLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// Stereo linear resampler package
// Shared widths, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slr_pkg;

    localparam int SAMPLE_W              = 32;
    localparam int RATIO_W               = 21;
    localparam int BLOCK_OUT_W           = 13;
    localparam int MAX_PER_STEP          = 64;
    localparam int CNT_W                 = 7;
    localparam int DEF_MAX_BLOCK_OUTPUTS = 4096;
    localparam int FRAC_BITS             = 16;

    typedef struct packed {
        logic load;
        logic issue;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic advance;
        logic pipe_empty;
    } status_t;

endpackage

>>> rtl/slr_ctrl.sv
// ----------------------------------------------------------------------------
// Stereo linear resampler controller
// Position accumulator, output budget and issue sequencing per source frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slr_ctrl #(
    parameter int MAX_BLOCK_OUTPUTS = slr_pkg::DEF_MAX_BLOCK_OUTPUTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            block_start,
    input  logic [slr_pkg::BLOCK_OUT_W-1:0] block_outputs,
    input  logic                            cfg_wen,
    input  logic [slr_pkg::RATIO_W-1:0]     cfg_wdata,
    input  slr_pkg::status_t                status,
    output slr_pkg::cmd_t                   cmd,
    output logic [slr_pkg::FRAC_BITS:0]     frac
);
    import slr_pkg::*;

    localparam int POS_W = FRAC_BITS + 6;
    localparam int WIDE  = (POS_W > RATIO_W) ? POS_W : RATIO_W;
    localparam int OL_W  = $clog2(MAX_BLOCK_OUTPUTS + 1);
    localparam int NW    = (OL_W > BLOCK_OUT_W) ? OL_W : BLOCK_OUT_W;

    localparam logic [POS_W-1:0] ONE      = POS_W'(1) << FRAC_BITS;
    localparam logic [WIDE-1:0]  RMIN     = WIDE'(1) << (FRAC_BITS - 6);
    localparam logic [WIDE-1:0]  RMAX     = WIDE'(16) << FRAC_BITS;
    localparam logic [WIDE-1:0]  RRESET   = WIDE'(1) << FRAC_BITS;
    localparam logic [NW-1:0]    NMAX     = NW'(MAX_BLOCK_OUTPUTS);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PER_STEP);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_PER_STEP - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [RATIO_W-1:0] ratio_reg;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [OL_W-1:0]    ol_reg, ol_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [WIDE-1:0]    ratio_wide;
    logic [WIDE-1:0]    step_wide;
    logic [POS_W-1:0]   step;
    logic [POS_W-1:0]   pos_adv;
    logic [NW-1:0]      n_ext;
    logic [NW-1:0]      n_sat;
    logic               more;
    logic               more_after;

    function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] p);
        wrap_pos = (p > ONE) ? (p - ONE) : '0;
    endfunction

    always_comb
    begin
        ratio_wide = WIDE'(ratio_reg);
        if (ratio_wide < RMIN)
        begin
            step_wide = RMIN;
        end
        else if (ratio_wide > RMAX)
        begin
            step_wide = RMAX;
        end
        else
        begin
            step_wide = ratio_wide;
        end
        step = step_wide[POS_W-1:0];
    end

    assign pos_adv    = pos_reg + step;
    assign n_ext      = NW'(block_outputs);
    assign n_sat      = (n_ext > NMAX) ? NMAX : n_ext;
    assign more       = (ol_reg != '0) && (pos_reg <= ONE) && (cnt_reg < CNT_MAX);
    assign more_after = (ol_reg != OL_W'(1)) && (pos_adv <= ONE) && (cnt_reg != CNT_LAST);

    assign in_ready = (state_reg == ST_IDLE);
    assign frac     = pos_reg[FRAC_BITS:0];

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        ol_next    = ol_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_RUN;
                    if (block_start)
                    begin
                        ol_next  = n_sat[OL_W-1:0];
                        pos_next = ONE;
                    end
                end
            end
            ST_RUN:
            begin
                if (!more)
                begin
                    pos_next   = wrap_pos(pos_reg);
                    state_next = ST_IDLE;
                end
                else if (status.advance)
                begin
                    cmd.issue = 1'b1;
                    cmd.last  = !more_after;
                    ol_next   = ol_reg - OL_W'(1);
                    cnt_next  = cnt_reg + CNT_W'(1);
                    if (more_after)
                    begin
                        pos_next = pos_adv;
                    end
                    else
                    begin
                        pos_next   = wrap_pos(pos_adv);
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ratio_reg <= RRESET[RATIO_W-1:0];
            pos_reg   <= '0;
            ol_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ol_reg    <= ol_next;
            cnt_reg   <= cnt_next;
            if (cfg_wen)
            begin
                ratio_reg <= cfg_wdata;
            end
        end
    end

endmodule

>>> rtl/slr_datapath.sv
// ----------------------------------------------------------------------------
// Stereo linear resampler datapath
// Sample history and a three-stage interpolation pipeline with output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  slr_pkg::cmd_t                       cmd,
    input  logic [slr_pkg::FRAC_BITS:0]         frac,
    input  logic signed [slr_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [slr_pkg::SAMPLE_W-1:0] right_in,
    output slr_pkg::status_t                    status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [slr_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [slr_pkg::SAMPLE_W-1:0] right_out,
    output logic                                last
);
    import slr_pkg::*;

    localparam int WT_W = FRAC_BITS + 2;
    localparam int PW   = SAMPLE_W + WT_W;
    localparam int SW   = PW + 1;

    localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [SW-1:0]      BIAS  = (SW'(1) << FRAC_BITS) - SW'(1);

    logic signed [SAMPLE_W-1:0] prev_l_reg, prev_r_reg;
    logic signed [SAMPLE_W-1:0] cur_l_reg, cur_r_reg;

    logic                       s1_valid_reg, s1_last_reg;
    logic signed [PW-1:0]       s1_la_reg, s1_lb_reg, s1_ra_reg, s1_rb_reg;
    logic                       s2_valid_reg, s2_last_reg;
    logic signed [SW-1:0]       s2_l_reg, s2_r_reg;
    logic                       out_valid_reg, out_last_reg;
    logic signed [SAMPLE_W-1:0] out_l_reg, out_r_reg;

    logic signed [WT_W-1:0]     w_cur, w_prev;
    logic signed [SW-1:0]       l_biased, r_biased;
    logic signed [SW-1:0]       l_shift, r_shift;
    logic                       advance;

    assign advance = !out_valid_reg || out_ready;

    assign w_cur  = signed'({1'b0, frac});
    assign w_prev = signed'({1'b0, ONE_F - frac});

    assign l_biased = s2_l_reg + (s2_l_reg[SW-1] ? signed'(BIAS) : signed'(SW'(0)));
    assign r_biased = s2_r_reg + (s2_r_reg[SW-1] ? signed'(BIAS) : signed'(SW'(0)));
    assign l_shift  = l_biased >>> FRAC_BITS;
    assign r_shift  = r_biased >>> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_l_reg    <= '0;
            prev_r_reg    <= '0;
            cur_l_reg     <= '0;
            cur_r_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_l_reg <= cur_l_reg;
                prev_r_reg <= cur_r_reg;
                cur_l_reg  <= left_in;
                cur_r_reg  <= right_in;
            end
            if (advance)
            begin
                s1_valid_reg  <= cmd.issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg  <= cmd.last;
            s1_la_reg    <= PW'(prev_l_reg) * PW'(w_prev);
            s1_lb_reg    <= PW'(cur_l_reg) * PW'(w_cur);
            s1_ra_reg    <= PW'(prev_r_reg) * PW'(w_prev);
            s1_rb_reg    <= PW'(cur_r_reg) * PW'(w_cur);
            s2_last_reg  <= s1_last_reg;
            s2_l_reg     <= SW'(s1_la_reg) + SW'(s1_lb_reg);
            s2_r_reg     <= SW'(s1_ra_reg) + SW'(s1_rb_reg);
            out_last_reg <= s2_last_reg;
            out_l_reg    <= l_shift[SAMPLE_W-1:0];
            out_r_reg    <= r_shift[SAMPLE_W-1:0];
        end
    end

    assign status.advance    = advance;
    assign status.pipe_empty = !s1_valid_reg && !s2_valid_reg && !out_valid_reg;

    assign out_valid = out_valid_reg;
    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;
    assign last      = out_last_reg;

endmodule

>>> rtl/stereo_linear_resampler.sv
// Path: output frames are issued by the controller, then registered in s1, s2, out.
// Throughput: one output per cycle while the output is not stalled; the input
// stays not ready from a frame's acceptance until the issue loop is done with it.
// Output stalls back-pressure the whole three-stage interpolation pipeline.
// Reset: asynchronous, active low; clears history, position, budget and
// loads the ratio register with 1.0.
// ----------------------------------------------------------------------------
// Stereo linear resampler
// Linear-interpolation sample rate converter for stereo frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_linear_resampler_macros.svh"

module stereo_linear_resampler #(
    parameter int MAX_BLOCK_OUTPUTS = slr_pkg::DEF_MAX_BLOCK_OUTPUTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wen,
    input  logic [slr_pkg::RATIO_W-1:0]         cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [slr_pkg::SAMPLE_W-1:0] left_in,
    input  logic signed [slr_pkg::SAMPLE_W-1:0] right_in,
    input  logic                                block_start,
    input  logic [slr_pkg::BLOCK_OUT_W-1:0]     block_outputs,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [slr_pkg::SAMPLE_W-1:0] left_out,
    output logic signed [slr_pkg::SAMPLE_W-1:0] right_out,
    output logic                                last
);
    import slr_pkg::*;

    cmd_t               cmd;
    status_t            status;
    logic [FRAC_BITS:0] frac;

    slr_ctrl #(
        .MAX_BLOCK_OUTPUTS (MAX_BLOCK_OUTPUTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .block_start   (block_start),
        .block_outputs (block_outputs),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .status        (status),
        .cmd           (cmd),
        .frac          (frac)
    );

    slr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .frac      (frac),
        .left_in   (left_in),
        .right_in  (right_in),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out),
        .last      (last)
    );

    `SLR_ASSERT_SAME(a_issue_advances, clk, rst_n, cmd.issue, status.advance, "issue while stalled")
    `SLR_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "request taken twice")
    `SLR_ASSERT_NEXT(a_no_phantom, clk, rst_n, status.pipe_empty && !cmd.issue, !out_valid, "output without issue")

endmodule

>>> verif/stereo_linear_resampler_tb.sv
// ----------------------------------------------------------------------------
// Stereo linear resampler testbench
// Drives source frames and ratio settings with random idle cycles on both
// channels. A scoreboard predicts every interpolated output frame and checks
// each output request against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_linear_resampler_tb;

    localparam int ONE_POS    = 1 << slr_pkg::FRAC_BITS;
    localparam int RATIO_MIN  = ONE_POS >> 6;
    localparam int RATIO_MAX  = ONE_POS << 4;
    localparam int DRAIN_WAIT = 12;
    localparam int LIMIT      = 400000;

    typedef struct {
        logic signed [slr_pkg::SAMPLE_W-1:0] left;
        logic signed [slr_pkg::SAMPLE_W-1:0] right;
        logic                                last;
    } out_frame_t;

    class resample_scoreboard;
        logic [slr_pkg::RATIO_W-1:0]         ratio;
        logic signed [slr_pkg::SAMPLE_W-1:0] hist_left;
        logic signed [slr_pkg::SAMPLE_W-1:0] hist_right;
        logic [23:0]                         position;
        logic [slr_pkg::BLOCK_OUT_W-1:0]     budget;
        out_frame_t                          expected_frames[$];
        int                                  mismatch_count;

        function new();
            ratio          = slr_pkg::RATIO_W'(ONE_POS);
            hist_left      = '0;
            hist_right     = '0;
            position       = '0;
            budget         = '0;
            mismatch_count = 0;
        endfunction

        function void set_ratio(input logic [slr_pkg::RATIO_W-1:0] value);
            ratio = value;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function logic signed [31:0] blend(input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic [23:0] fr);
            longint num;
            num = longint'(a) * (longint'(ONE_POS) - longint'(fr))
                + longint'(b) * longint'(fr);
            return 32'(num / longint'(ONE_POS));
        endfunction

        function void note_frame(input logic signed [31:0] l,
                                 input logic signed [31:0] r,
                                 input logic bs,
                                 input logic [slr_pkg::BLOCK_OUT_W-1:0] bo);
            logic [23:0] step;
            out_frame_t  batch[$];
            out_frame_t  f;
            int          i;
            step = 24'(ratio);
            if (step < RATIO_MIN)
                step = 24'(RATIO_MIN);
            if (step > RATIO_MAX)
                step = 24'(RATIO_MAX);
            if (bs)
            begin
                budget   = (bo > slr_pkg::DEF_MAX_BLOCK_OUTPUTS) ?
                           slr_pkg::BLOCK_OUT_W'(slr_pkg::DEF_MAX_BLOCK_OUTPUTS) : bo;
                position = 24'(ONE_POS);
            end
            while (budget != 0 && position <= ONE_POS && batch.size() < slr_pkg::MAX_PER_STEP)
            begin
                f.left  = blend(hist_left, l, position);
                f.right = blend(hist_right, r, position);
                f.last  = 1'b0;
                batch.push_back(f);
                budget   = budget - 1'b1;
                position = position + step;
            end
            for (i = 0; i < batch.size(); i++)
            begin
                f      = batch[i];
                f.last = (i == batch.size() - 1);
                expected_frames.push_back(f);
            end
            if (position > ONE_POS)
                position = position - 24'(ONE_POS);
            else
                position = '0;
            hist_left  = l;
            hist_right = r;
        endfunction

        task report(input string msg);
            if (mismatch_count < 100)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_frame(input logic signed [31:0] l,
                         input logic signed [31:0] r,
                         input logic lst);
            out_frame_t want;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected output L=%0d R=%0d last=%0b", l, r, lst));
                return;
            end
            want = expected_frames.pop_front();
            if (l !== want.left)
                report($sformatf("left_out %0d, expected %0d", l, want.left));
            if (r !== want.right)
                report($sformatf("right_out %0d, expected %0d", r, want.right));
            if (lst !== want.last)
                report($sformatf("last %0b, expected %0b", lst, want.last));
        endtask
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_wen = 1'b0;
    logic [slr_pkg::RATIO_W-1:0]         cfg_wdata = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [slr_pkg::SAMPLE_W-1:0] left_in = '0;
    logic signed [slr_pkg::SAMPLE_W-1:0] right_in = '0;
    logic                                block_start = 1'b0;
    logic [slr_pkg::BLOCK_OUT_W-1:0]     block_outputs = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [slr_pkg::SAMPLE_W-1:0] left_out;
    logic signed [slr_pkg::SAMPLE_W-1:0] right_out;
    logic                                last;

    resample_scoreboard sb = new();
    logic               quiet = 1'b0;
    int                 cycle_count = 0;

    stereo_linear_resampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_in       (left_in),
        .right_in      (right_in),
        .block_start   (block_start),
        .block_outputs (block_outputs),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_out      (left_out),
        .right_out     (right_out),
        .last          (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= quiet || ($urandom_range(0, 99) >= 14);
        if (rst_n && out_valid && out_ready)
            sb.check_frame(left_out, right_out, last);
    end

    function logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_frame(input logic [31:0] l, input logic [31:0] r,
                              input logic bs, input logic [12:0] bo);
        while (!quiet && $urandom_range(0, 99) < 14)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        left_in       <= l;
        right_in      <= r;
        block_start   <= bs;
        block_outputs <= bo;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_frame(l, r, bs, bo);
    endtask

    task automatic write_ratio(input logic [slr_pkg::RATIO_W-1:0] value);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.set_ratio(value);
    endtask

    initial
    begin : stimulus
        int                              phase;
        int                              sent;
        int                              frames;
        int                              k;
        logic [slr_pkg::RATIO_W-1:0]     ratio_val;
        logic [slr_pkg::BLOCK_OUT_W-1:0] count_val;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // block never started, then short block, spent block and empty block
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 13'h1FFF);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 13'd3);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 13'd0);
        send_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 13'd0);
        send_frame(32'h1234_5678, 32'h8765_4321, 1'b0, 13'd0);
        send_frame(32'h0000_0001, 32'hFFFF_FFFE, 1'b1, 13'd0);
        send_frame(32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 13'h1FFF);
        send_frame(32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 13'h0AAA);

        write_ratio(slr_pkg::RATIO_W'(RATIO_MIN));
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 13'd200);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 13'h1555);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 13'd0);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 13'd0);

        write_ratio(slr_pkg::RATIO_W'(RATIO_MAX));
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 13'd5);
        for (k = 0; k < 4; k++)
            send_frame(pick_sample(), pick_sample(), 1'b0, 13'd0);

        // ratio below the lower bound clamps to 1/64
        write_ratio('0);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 13'd70);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 13'd0);

        // ratio above the upper bound clamps to 16
        write_ratio('1);
        send_frame(32'h0000_0100, 32'hFFFF_FF00, 1'b1, 13'd3);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 13'd0);

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: ratio_val = slr_pkg::RATIO_W'($urandom_range(RATIO_MIN, RATIO_MAX));
                1: ratio_val = slr_pkg::RATIO_W'(24576);
                2: ratio_val = slr_pkg::RATIO_W'($urandom_range(RATIO_MIN, 2 * ONE_POS));
                3: ratio_val = slr_pkg::RATIO_W'($urandom_range(ONE_POS, RATIO_MAX));
                default: ratio_val = slr_pkg::RATIO_W'($urandom_range(RATIO_MIN, ONE_POS));
            endcase
            write_ratio(ratio_val);
            quiet <= (phase == 2);
            sent = 0;
            while (sent < 20)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    if ($urandom_range(0, 15) == 0)
                        count_val = slr_pkg::BLOCK_OUT_W'($urandom_range(0, 8191));
                    else
                        count_val = slr_pkg::BLOCK_OUT_W'($urandom_range(1, 48));
                    send_frame(pick_sample(), pick_sample(), 1'b1, count_val);
                    frames = $urandom_range(1, 8);
                    for (k = 0; k < frames; k++)
                        send_frame(pick_sample(), pick_sample(), 1'b0,
                                   slr_pkg::BLOCK_OUT_W'($urandom));
                    sent += frames + 1;
                end
                else
                begin
                    send_frame(pick_sample(), pick_sample(), 1'($urandom),
                               slr_pkg::BLOCK_OUT_W'($urandom));
                    sent++;
                end
            end
        end
        quiet <= 1'b0;

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT * 2) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected outputs never arrived", sb.pending()));

        if (sb.mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
